/* rtl/triangle_check_classify_area_defines.svh */
// Assertion macros for the triangle check, classify and area block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TRIANGLE_CHECK_CLASSIFY_AREA_DEFINES_SVH
`define TRIANGLE_CHECK_CLASSIFY_AREA_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle whenever ante holds
`define TCCA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Check that cons holds in the cycle after ante holds
`define TCCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define TCCA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TCCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/tcca_pkg.sv */
// Package for the triangle check, classify and area block: widths, depths and types.
// Used by every RTL module of the block; depends on nothing.
package tcca_pkg;

    // Side width and the widths that follow from it
    localparam int SIDE_BITS   = 12;
    localparam int SUM_W       = SIDE_BITS + 1;
    localparam int PERIM_W     = SIDE_BITS + 2;
    localparam int PX_W        = PERIM_W + SUM_W;
    localparam int YZ_W        = 2 * SUM_W;
    localparam int PROD_FULL_W = PX_W + YZ_W;
    localparam int ROOT_W      = 2 * SIDE_BITS + 1;
    localparam int PROD_W      = 2 * ROOT_W;
    localparam int REM_W       = ROOT_W + 1;

    // Queue depths (powers of two, so pointers wrap on their own)
    localparam int MID_DEPTH = 4;
    localparam int MID_AW    = $clog2(MID_DEPTH);
    localparam int MID_CNT_W = MID_AW + 1;
    localparam int OUT_DEPTH = 32;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int CRED_W    = OUT_AW + 1;

    typedef logic [SIDE_BITS-1:0] t_side;

    typedef struct packed {
        t_side side_a;
        t_side side_b;
        t_side side_c;
    } t_in_item;

    typedef struct packed {
        logic               is_valid;
        logic [PERIM_W-1:0] perimeter;
        logic [ROOT_W-1:0]  area_times_four;
        logic               is_equilateral;
        logic               is_isosceles;
    } t_out_item;

    // Classification that rides alongside the arithmetic
    typedef struct packed {
        logic               valid;
        logic               equi;
        logic               iso;
        logic [PERIM_W-1:0] perim;
    } t_tag;

    // Classified triangle handed from the front to the back
    typedef struct packed {
        t_tag             tag;
        logic [SUM_W-1:0] diff_x;
        logic [SUM_W-1:0] diff_y;
        logic [SUM_W-1:0] diff_z;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_job_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

/* rtl/triangle_check_classify_area.sv */
// Top level of the triangle check, classify and area block.
// Depends on tcca_pkg, tcca_front, tcca_job_queue and tcca_back.
//
// Input channel: present three side lengths on i_in_item and raise push; a
// transaction completes at a rising edge with push high and full low.
// Result channel: while empty is low the oldest result sits on o_out_item;
// raise pop to take it, a transaction completing at an edge with pop high
// and empty low. Every input transaction yields exactly one result, in order.
// Throughput: one transaction per cycle sustained while nothing stalls. A result
// passes through the front register, the job queue, two multiplier stages, a
// 25-stage square root pipeline that resolves one root bit per stage, and the
// result queue before it becomes visible.
// Stalls: the back end reserves a slot in the 32-entry result queue before
// it starts a job, so a stalled receiver fills that queue, then the 4-entry
// job queue, then the front register, and only then raises full.
// Reset (i_rst_n low, synchronous): all queues empty, nothing in flight,
// full low and empty high.
module triangle_check_classify_area (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  tcca_pkg::t_in_item   i_in_item,
    output logic                 empty,
    input  logic                 pop,
    output tcca_pkg::t_out_item  o_out_item
);
    import tcca_pkg::*;

    t_job_push   w_mid_in;
    t_queue_stat w_mid_stat;
    t_job        w_mid_job;
    logic        w_issue;

    // Accept and classify
    tcca_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_in_item),
        .i_mid_stat (w_mid_stat),
        .o_mid      (w_mid_in)
    );

    // Decouple front and back
    tcca_job_queue u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (w_mid_in),
        .i_pop   (w_issue),
        .o_stat  (w_mid_stat),
        .o_job   (w_mid_job)
    );

    // Compute area and deliver results
    tcca_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_stat  (w_mid_stat),
        .i_job       (w_mid_job),
        .o_issue     (w_issue),
        .i_out_pop   (pop),
        .o_out_empty (empty),
        .o_out_item  (o_out_item)
    );

endmodule

/* rtl/tcca_front.sv */
// Front end: accepts side triples, checks validity, classifies and forms Heron's factors.
// Depends on tcca_pkg; feeds tcca_job_queue.
module tcca_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  tcca_pkg::t_in_item     i_item,
    input  tcca_pkg::t_queue_stat  i_mid_stat,
    output tcca_pkg::t_job_push    o_mid
);
    import tcca_pkg::*;

    logic [SUM_W-1:0] w_sum_ab;
    logic [SUM_W-1:0] w_sum_bc;
    logic [SUM_W-1:0] w_sum_ca;
    logic             w_valid;
    logic             w_equi;
    logic             w_iso;
    t_job             w_job;
    t_job             r_job;
    logic             r_vld;
    logic             n_vld;
    logic             w_accept;
    logic             w_move;

    // Pairwise sums for the strict triangle inequality
    assign w_sum_ab = SUM_W'(i_item.side_a) + SUM_W'(i_item.side_b);
    assign w_sum_bc = SUM_W'(i_item.side_b) + SUM_W'(i_item.side_c);
    assign w_sum_ca = SUM_W'(i_item.side_c) + SUM_W'(i_item.side_a);

    assign w_valid = (i_item.side_a != '0) && (i_item.side_b != '0) && (i_item.side_c != '0)
                     && (w_sum_ab > SUM_W'(i_item.side_c))
                     && (w_sum_bc > SUM_W'(i_item.side_a))
                     && (w_sum_ca > SUM_W'(i_item.side_b));

    assign w_equi = w_valid && (i_item.side_a == i_item.side_b)
                    && (i_item.side_b == i_item.side_c);
    assign w_iso  = w_valid && !w_equi
                    && ((i_item.side_a == i_item.side_b) || (i_item.side_b == i_item.side_c)
                        || (i_item.side_c == i_item.side_a));

    // Build the job; an invalid triangle carries all zeros so its area comes out zero
    always_comb begin
        w_job = '0;
        if (w_valid) begin
            w_job.tag.valid = 1'b1;
            w_job.tag.equi  = w_equi;
            w_job.tag.iso   = w_iso;
            w_job.tag.perim = PERIM_W'(i_item.side_a) + PERIM_W'(i_item.side_b)
                              + PERIM_W'(i_item.side_c);
            w_job.diff_x    = w_sum_bc - SUM_W'(i_item.side_a);
            w_job.diff_y    = w_sum_ca - SUM_W'(i_item.side_b);
            w_job.diff_z    = w_sum_ab - SUM_W'(i_item.side_c);
        end
    end

    // Hold the classified item until the queue takes it
    assign w_move   = r_vld && !i_mid_stat.full;
    assign o_full   = r_vld && i_mid_stat.full;
    assign w_accept = i_push && !o_full;

    always_comb begin
        priority if (w_accept) begin
            n_vld = 1'b1;
        end else if (w_move) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= w_job;
        end
    end

    assign o_mid.push = w_move;
    assign o_mid.job  = r_job;

endmodule

/* rtl/tcca_job_queue.sv */
// Short queue of classified jobs between the front end and the arithmetic back end.
// Depends on tcca_pkg and the assertion macros header.
`include "triangle_check_classify_area_defines.svh"

module tcca_job_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tcca_pkg::t_job_push    i_in,
    input  logic                   i_pop,
    output tcca_pkg::t_queue_stat  o_stat,
    output tcca_pkg::t_job         o_job
);
    import tcca_pkg::*;

    t_job                r_mem [MID_DEPTH];
    logic [MID_AW-1:0]   r_wr_ptr;
    logic [MID_AW-1:0]   r_rd_ptr;
    logic [MID_CNT_W-1:0] r_cnt;
    logic [MID_CNT_W-1:0] n_cnt;

    assign o_stat.full  = (r_cnt == MID_CNT_W'(MID_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rd_ptr];

    // Store an incoming job
    always_ff @(posedge i_clk) begin
        if (i_in.push) begin
            r_mem[r_wr_ptr] <= i_in.job;
        end
    end

    assign n_cnt = r_cnt + MID_CNT_W'(i_in.push) - MID_CNT_W'(i_pop);

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_in.push) begin
                r_wr_ptr <= r_wr_ptr + MID_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + MID_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    `TCCA_ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, i_in.push, !o_stat.full)
    `TCCA_ASSERT_IMPL(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, !o_stat.empty)
    `TCCA_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= MID_CNT_W'(MID_DEPTH))
    `TCCA_ASSERT_NEXT(a_cnt_grows, i_clk, i_rst_n, i_in.push && !i_pop, r_cnt == $past(r_cnt) + MID_CNT_W'(1))

endmodule

/* rtl/tcca_back.sv */
// Back end: pipelined Heron product, pipelined bit-per-stage square root, result queue.
// Depends on tcca_pkg and the assertion macros header; fed by tcca_job_queue.
`include "triangle_check_classify_area_defines.svh"

module tcca_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tcca_pkg::t_queue_stat  i_mid_stat,
    input  tcca_pkg::t_job         i_job,
    output logic                   o_issue,
    input  logic                   i_out_pop,
    output logic                   o_out_empty,
    output tcca_pkg::t_out_item    o_out_item
);
    import tcca_pkg::*;

    // Multiplier stage
    logic                   r_s1_vld;
    logic [PX_W-1:0]        r_px;
    logic [YZ_W-1:0]        r_yz;
    t_tag                   r_s1_tag;
    logic [PROD_FULL_W-1:0] w_prod_full;

    // Square root stages; element 0 holds the full product
    logic                   r_sq_vld  [0:ROOT_W];
    logic [PROD_W-1:0]      r_sq_rad  [0:ROOT_W];
    logic [REM_W-1:0]       r_sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]      r_sq_root [0:ROOT_W];
    t_tag                   r_sq_tag  [0:ROOT_W];

    // Result queue and credit
    t_out_item              r_out_mem [OUT_DEPTH];
    logic [OUT_AW-1:0]      r_wr_ptr;
    logic [OUT_AW-1:0]      r_rd_ptr;
    logic [CRED_W-1:0]      r_out_cnt;
    logic [CRED_W-1:0]      r_credit;
    logic                   w_wr;
    logic                   w_rd;
    t_out_item              w_wr_item;

    // Issue only while the result queue has a slot reserved for the job
    assign o_issue = !i_mid_stat.empty && (r_credit != CRED_W'(OUT_DEPTH));

    // First products: P*x and y*z
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= o_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px     <= PX_W'(i_job.tag.perim) * PX_W'(i_job.diff_x);
        r_yz     <= YZ_W'(i_job.diff_y) * YZ_W'(i_job.diff_z);
        r_s1_tag <= i_job.tag;
    end

    // Full Heron product; its value always fits the radicand width
    assign w_prod_full = PROD_FULL_W'(r_px) * PROD_FULL_W'(r_yz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else begin
            r_sq_vld[0] <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_rad[0]  <= w_prod_full[PROD_W-1:0];
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_tag[0]  <= r_s1_tag;
    end

    // One root bit per stage: bring down two radicand bits, try (root*4 + 1)
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [REM_W+1:0] w_cur;
        logic [REM_W+1:0] w_trial;
        logic [REM_W+1:0] w_diff;
        logic             w_ge;

        assign w_cur   = {r_sq_rem[k], r_sq_rad[k][PROD_W-1 -: 2]};
        assign w_trial = {1'b0, r_sq_root[k], 2'b01};
        assign w_diff  = w_cur - w_trial;
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_rad[k+1]  <= {r_sq_rad[k][PROD_W-3:0], 2'b00};
            r_sq_rem[k+1]  <= w_ge ? w_diff[REM_W-1:0] : w_cur[REM_W-1:0];
            r_sq_root[k+1] <= {r_sq_root[k][ROOT_W-2:0], w_ge};
            r_sq_tag[k+1]  <= r_sq_tag[k];
        end
    end

    // Assemble the finished result
    always_comb begin
        w_wr_item.is_valid        = r_sq_tag[ROOT_W].valid;
        w_wr_item.perimeter       = r_sq_tag[ROOT_W].perim;
        w_wr_item.area_times_four = r_sq_root[ROOT_W];
        w_wr_item.is_equilateral  = r_sq_tag[ROOT_W].equi;
        w_wr_item.is_isosceles    = r_sq_tag[ROOT_W].iso;
    end

    assign w_wr        = r_sq_vld[ROOT_W];
    assign o_out_empty = (r_out_cnt == '0);
    assign w_rd        = i_out_pop && !o_out_empty;
    assign o_out_item  = r_out_mem[r_rd_ptr];

    // Store results
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_out_mem[r_wr_ptr] <= w_wr_item;
        end
    end

    // Advance result queue pointers, occupancy and outstanding credit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_out_cnt <= '0;
            r_credit  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + OUT_AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + OUT_AW'(1);
            end
            r_out_cnt <= r_out_cnt + CRED_W'(w_wr) - CRED_W'(w_rd);
            r_credit  <= r_credit + CRED_W'(o_issue) - CRED_W'(w_rd);
        end
    end

    `TCCA_ASSERT_IMPL(a_credit_bound, i_clk, i_rst_n, 1'b1, r_credit <= CRED_W'(OUT_DEPTH))
    `TCCA_ASSERT_IMPL(a_cnt_within_credit, i_clk, i_rst_n, 1'b1, r_out_cnt <= r_credit)
    `TCCA_ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, w_wr, r_out_cnt != CRED_W'(OUT_DEPTH))
    `TCCA_ASSERT_NEXT(a_issue_enters, i_clk, i_rst_n, o_issue, r_s1_vld)
    `TCCA_ASSERT_IMPL(a_invalid_zero, i_clk, i_rst_n, !o_out_empty && !o_out_item.is_valid, (o_out_item.perimeter == '0) && (o_out_item.area_times_four == '0))

endmodule
